// File: design/pdst_pkg.sv
// Shared types and constants for the partitioned dense session table.
package pdst_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_BIND     = 3'd1,
        OP_REBIND   = 3'd2,
        OP_FIND     = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_READ     = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_WRONG_STATE = 3'd5,
        ST_ENTITY_USED = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_SCAN,
        S_ENT_SCAN,
        S_DECIDE,
        S_PLAN,
        S_SWAP_RD,
        S_SWAP_WR,
        S_REPORT_RD,
        S_REPORT,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic             load;       // capture the input beat
        logic             clr_scan;   // restart the scan index
        logic             scan_step;  // advance the scan index
        logic             key_scan;   // compare session keys at the scan index
        logic             ent_scan;   // compare entity keys at the scan index
        logic             decide;     // settle status and plan the writes
        logic             swap_rd;    // read both entries of the pending swap
        logic             swap_wr;    // write the swapped or new entries
        logic             report_rd;  // read the entry to report
        logic             report;     // capture the result beat
        logic             out_take;   // result beat accepted
    } t_ctrl;

    // Datapath to controller.
    typedef struct packed {
        logic key_done;
        logic ent_done;
        logic need_ent;
        logic need_swap;
        logic need_report;
        logic more_swaps;
    } t_stat;
endpackage

// File: design/pdst_if.sv
// Valid/ready channel interfaces for the session table.
interface pdst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] session_key;
    logic [31:0] player_id;
    logic [63:0] entity_key;
    logic [5:0]  dense_index;
    modport source(output valid, opcode, session_key, player_id, entity_key, dense_index,
                   input ready);
    modport sink(input valid, opcode, session_key, player_id, entity_key, dense_index,
                 output ready);
endinterface

interface pdst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] found_session_key;
    logic [31:0] found_player_id;
    logic [63:0] found_entity_key;
    logic        found_joined;
    logic [5:0]  found_position;
    logic [6:0]  session_count;
    logic [6:0]  joined_count;
    modport source(output valid, status, found_session_key, found_player_id,
                   found_entity_key, found_joined, found_position, session_count,
                   joined_count, input ready);
    modport sink(input valid, status, found_session_key, found_player_id,
                 found_entity_key, found_joined, found_position, session_count,
                 joined_count, output ready);
endinterface

// File: design/pdst_ctrl.sv
// Sequencing state machine of the session table.
module pdst_ctrl import pdst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // The plan registered in the decide cycle is acted on in the cycle after it, in the plan state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_KEY_SCAN;
            S_KEY_SCAN:  if (i_stat.key_done)
                             n_state = i_stat.need_ent ? S_ENT_SCAN : S_DECIDE;
            S_ENT_SCAN:  if (i_stat.ent_done) n_state = S_DECIDE;
            S_DECIDE:    n_state = S_PLAN;
            S_PLAN:      n_state = i_stat.need_swap ? S_SWAP_RD :
                                   (i_stat.need_report ? S_REPORT_RD : S_REPORT);
            S_SWAP_RD:   n_state = S_SWAP_WR;
            S_SWAP_WR:   n_state = i_stat.more_swaps ? S_SWAP_RD : S_REPORT;
            S_REPORT_RD: n_state = S_REPORT;
            S_REPORT:    n_state = S_OUT;
            S_OUT:       if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctrl.load = i_in_valid;
                o_ctrl.clr_scan = 1'b1;
            end
            S_KEY_SCAN: begin
                o_ctrl.key_scan = 1'b1;
                o_ctrl.scan_step = 1'b1;
                o_ctrl.clr_scan = i_stat.key_done;
            end
            S_ENT_SCAN: begin
                o_ctrl.ent_scan = 1'b1;
                o_ctrl.scan_step = 1'b1;
            end
            S_DECIDE:    o_ctrl.decide = 1'b1;
            S_SWAP_RD:   o_ctrl.swap_rd = 1'b1;
            S_SWAP_WR:   o_ctrl.swap_wr = 1'b1;
            S_REPORT_RD: o_ctrl.report_rd = 1'b1;
            S_REPORT:    o_ctrl.report = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_ctrl.out_take = i_out_ready;
            end
            default: ;
        endcase
    end

    a_one_sided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output both open");
    a_out_follows_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.report |=> o_out_valid) else $error("result not presented");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
endmodule

// File: design/pdst_dp.sv
// Datapath of the session table: entry memories, scan unit, counts and result.
module pdst_dp import pdst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_session_key,
    input  logic [31:0] i_player_id,
    input  logic [63:0] i_entity_key,
    input  logic [5:0]  i_dense_index,
    output t_stat       o_stat,
    output logic [2:0]  o_status,
    output logic [63:0] o_found_session_key,
    output logic [31:0] o_found_player_id,
    output logic [63:0] o_found_entity_key,
    output logic        o_found_joined,
    output logic [5:0]  o_found_position,
    output logic [6:0]  o_session_count,
    output logic [6:0]  o_joined_count
);
    // Each entry packs session key, player id and entity key.
    localparam int EntW = 160;

    logic [EntW-1:0] r_mem [Capacity];

    logic [2:0]      r_op;
    logic [63:0]     r_key;
    logic [31:0]     r_pid;
    logic [63:0]     r_ent;
    logic [IdxW-1:0] r_didx;
    logic [CntW-1:0] r_stored, r_joined;
    logic [CntW-1:0] r_scan;
    logic [IdxW-1:0] r_pos;
    logic            r_hit, r_ent_hit;
    t_status         r_status;
    logic            r_report;
    // Swap plan: up to two exchanges of rows a and b.
    logic [1:0]      r_swaps;
    logic [IdxW-1:0] r_sa, r_sb;
    logic            r_phase;

    logic [IdxW-1:0] scan_idx;
    logic            in_key_range, in_ent_range, mem_key_eq, mem_ent_eq;
    logic [IdxW-1:0] addr_a;
    logic [EntW-1:0] rd_a, rd_b;

    assign scan_idx = r_scan[IdxW-1:0];
    assign in_key_range = r_scan < r_stored;
    assign in_ent_range = r_scan < r_joined;

    // Port A serves the scan, the first row of a swap and the report read.
    always_comb begin
        if (i_ctrl.swap_rd) addr_a = r_sa;
        else if (i_ctrl.report_rd) addr_a = r_pos;
        else addr_a = scan_idx;
    end

    always_ff @(posedge i_clk) begin
        rd_a <= r_mem[addr_a];
    end
    always_ff @(posedge i_clk) begin
        rd_b <= r_mem[r_sb];
    end

    // rd_a is registered from the row at r_scan, so the scan index is compared via r_lag.
    logic [CntW-1:0] r_lag;
    logic            r_lag_vk, r_lag_ve;
    always_ff @(posedge i_clk) begin
        r_lag <= r_scan;
        r_lag_vk <= (i_ctrl.key_scan && in_key_range);
        r_lag_ve <= (i_ctrl.ent_scan && in_ent_range);
    end
    assign mem_key_eq = r_lag_vk && rd_a[159:96] == r_key;
    assign mem_ent_eq = r_lag_ve && rd_a[63:0] == r_ent;

    // The hit seen in this cycle is not registered yet when the scan ends on it.
    logic            hit_now, need_ent_scan;
    logic [IdxW-1:0] pos_now;
    assign hit_now = r_hit || mem_key_eq;
    assign pos_now = r_hit ? r_pos : r_lag[IdxW-1:0];
    assign need_ent_scan = hit_now && ((r_op == OP_BIND && {1'b0, pos_now} >= r_joined) ||
                           (r_op == OP_REBIND && {1'b0, pos_now} < r_joined));

    // Scan is complete when a hit is seen or the index has passed the range and
    // its last read result has been compared.
    assign o_stat.key_done = i_ctrl.key_scan && (mem_key_eq || r_hit ||
                             (!in_key_range && !r_lag_vk));
    assign o_stat.ent_done = i_ctrl.ent_scan && (mem_ent_eq || r_ent_hit ||
                             (!in_ent_range && !r_lag_ve));
    assign o_stat.need_ent = need_ent_scan;
    assign o_stat.need_swap = r_swaps != 2'd0;
    assign o_stat.need_report = r_report;
    assign o_stat.more_swaps = r_swaps > 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_joined <= '0;
            r_swaps <= '0;
            r_phase <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_op <= i_opcode;
                r_key <= i_session_key;
                r_pid <= i_player_id;
                r_ent <= i_entity_key;
                r_didx <= i_dense_index;
                r_hit <= 1'b0;
                r_ent_hit <= 1'b0;
                r_phase <= 1'b0;
            end
            if (i_ctrl.clr_scan) r_scan <= '0;
            else if (i_ctrl.scan_step && !(mem_key_eq || mem_ent_eq)) r_scan <= r_scan + 1'b1;
            if (mem_key_eq && !r_hit) begin
                r_hit <= 1'b1;
                r_pos <= r_lag[IdxW-1:0];
            end
            if (mem_ent_eq) r_ent_hit <= 1'b1;
            if (i_ctrl.decide) begin
                r_report <= 1'b0;
                r_swaps <= '0;
                if (r_op > OP_READ || (r_op != OP_READ && r_key == '0)) begin
                    r_status <= ST_INVALID;
                end else begin
                    unique case (t_opcode'(r_op))
                        OP_REGISTER: begin
                            if (r_hit) r_status <= ST_DUPLICATE;
                            else if (r_stored >= CntW'(Capacity)) r_status <= ST_FULL;
                            else begin
                                r_status <= ST_OK;
                                r_sa <= r_stored[IdxW-1:0];
                                r_sb <= r_stored[IdxW-1:0];
                                r_swaps <= 2'd1;
                            end
                        end
                        OP_BIND: begin
                            if (r_pid == '0 || r_ent == '0) r_status <= ST_INVALID;
                            else if (!r_hit) r_status <= ST_NOT_FOUND;
                            else if ({1'b0, r_pos} < r_joined) r_status <= ST_WRONG_STATE;
                            else if (r_ent_hit) r_status <= ST_ENTITY_USED;
                            else begin
                                r_status <= ST_OK;
                                r_sa <= r_pos;
                                r_sb <= r_joined[IdxW-1:0];
                                r_swaps <= 2'd1;
                            end
                        end
                        OP_REBIND: begin
                            if (r_ent == '0) r_status <= ST_INVALID;
                            else if (!r_hit) r_status <= ST_NOT_FOUND;
                            else if ({1'b0, r_pos} >= r_joined) r_status <= ST_WRONG_STATE;
                            else if (r_ent_hit) r_status <= ST_ENTITY_USED;
                            else begin
                                r_status <= ST_OK;
                                r_sa <= r_pos;
                                r_sb <= r_pos;
                                r_swaps <= 2'd1;
                            end
                        end
                        OP_FIND: begin
                            if (!r_hit) r_status <= ST_NOT_FOUND;
                            else begin
                                r_status <= ST_OK;
                                r_report <= 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (!r_hit) r_status <= ST_NOT_FOUND;
                            else begin
                                r_status <= ST_OK;
                                if ({1'b0, r_pos} < r_joined) begin
                                    r_sa <= r_pos;
                                    r_sb <= IdxW'(r_joined - 1'b1);
                                    r_swaps <= 2'd2;
                                end else begin
                                    r_sa <= r_pos;
                                    r_sb <= IdxW'(r_stored - 1'b1);
                                    r_swaps <= 2'd1;
                                    r_phase <= 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            if ({1'b0, r_didx} >= r_stored) r_status <= ST_NOT_FOUND;
                            else begin
                                r_status <= ST_OK;
                                r_pos <= r_didx;
                                r_report <= 1'b1;
                            end
                        end
                        default: r_status <= ST_INVALID;
                    endcase
                end
            end
            if (i_ctrl.swap_wr) begin
                r_swaps <= r_swaps - 1'b1;
                unique case (t_opcode'(r_op))
                    OP_REGISTER: r_stored <= r_stored + 1'b1;
                    OP_BIND:     r_joined <= r_joined + 1'b1;
                    OP_REMOVE: begin
                        if (!r_phase) begin
                            r_joined <= r_joined - 1'b1;
                            r_phase <= 1'b1;
                            r_sa <= r_sb;
                            r_sb <= IdxW'(r_stored - 1'b1);
                        end else begin
                            r_stored <= r_stored - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Row writes: both swapped rows, or the single row that is updated.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.swap_wr) begin
            unique case (t_opcode'(r_op))
                OP_REGISTER: r_mem[r_sa] <= {r_key, 32'd0, 64'd0};
                OP_BIND: begin
                    r_mem[r_sa] <= rd_b;
                    r_mem[r_sb] <= {rd_a[159:96], r_pid, r_ent};
                end
                OP_REBIND: r_mem[r_sa] <= {rd_a[159:64], r_ent};
                default: begin
                    r_mem[r_sa] <= rd_b;
                    r_mem[r_sb] <= rd_a;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.report) begin
            o_status <= r_status;
            o_session_count <= 7'(r_stored);
            o_joined_count <= 7'(r_joined);
            if (r_report) begin
                o_found_session_key <= rd_a[159:96];
                o_found_player_id <= rd_a[95:64];
                o_found_entity_key <= rd_a[63:0];
                o_found_joined <= {1'b0, r_pos} < r_joined;
                o_found_position <= 6'(r_pos);
            end else begin
                o_found_session_key <= '0;
                o_found_player_id <= '0;
                o_found_entity_key <= '0;
                o_found_joined <= 1'b0;
                o_found_position <= '0;
            end
        end
    end

    a_counts_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_joined <= r_stored) else $error("joined count above stored count");
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CntW'(Capacity)) else $error("stored count above capacity");
    a_swap_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.swap_wr |-> r_status == ST_OK)
        else $error("table written on a failed operation");
    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.report && r_report |-> r_status == ST_OK)
        else $error("entry reported on a failed operation");
endmodule

// File: design/partitioned_dense_session_table.sv
// Top level of the partitioned dense session table.
// One operation is taken at a time and answered by one result beat. An
// operation costs a key search over the stored entries (one entry per cycle,
// stopping at the first match), an entity search over the joined entries for
// bind and rebind, then up to two read and write passes over the single entry
// memory for swaps. There is no clearing pass: the counts reset to zero and
// only entries below the stored count are ever used.
module partitioned_dense_session_table import pdst_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    pdst_in_if.sink    i_in,
    pdst_out_if.source o_out
);
    t_ctrl ctrl;
    t_stat stat;

    pdst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    pdst_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .i_opcode            (i_in.opcode),
        .i_session_key       (i_in.session_key),
        .i_player_id         (i_in.player_id),
        .i_entity_key        (i_in.entity_key),
        .i_dense_index       (i_in.dense_index),
        .o_stat              (stat),
        .o_status            (o_out.status),
        .o_found_session_key (o_out.found_session_key),
        .o_found_player_id   (o_out.found_player_id),
        .o_found_entity_key  (o_out.found_entity_key),
        .o_found_joined      (o_out.found_joined),
        .o_found_position    (o_out.found_position),
        .o_session_count     (o_out.session_count),
        .o_joined_count      (o_out.joined_count)
    );
endmodule

// File: test/partitioned_dense_session_table_tb.sv
// Self-checking testbench for the partitioned dense session table.
module partitioned_dense_session_table_tb;
    import pdst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] session_key;
        logic [31:0] player_id;
        logic [63:0] entity_key;
        logic [5:0]  dense_index;
    } t_op_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_session_key;
        logic [31:0] found_player_id;
        logic [63:0] found_entity_key;
        logic        found_joined;
        logic [5:0]  found_position;
        logic [6:0]  session_count;
        logic [6:0]  joined_count;
    } t_answer;

    // A directed row: the operation, and optionally the answer typed in by hand.
    typedef struct {
        t_op_beat op;
        bit       has_answer;
        t_answer  answer;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pdst_in_if  op_ch();
    pdst_out_if ans_ch();

    partitioned_dense_session_table DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch.sink),
        .o_out  (ans_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the table.
    logic [63:0] tbl_key [Capacity];
    logic [31:0] tbl_pid [Capacity];
    logic [63:0] tbl_ent [Capacity];
    int          n_stored;
    int          n_joined;

    t_answer pending_answers[$];
    int      mismatches;
    int      sent_ops;

    function automatic int find_key(logic [63:0] key);
        for (int i = 0; i < n_stored; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return Capacity;
    endfunction

    function automatic bit entity_held(logic [63:0] ent);
        for (int i = 0; i < n_joined; i++) begin
            if (tbl_ent[i] == ent) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void swap_rows(int a, int b);
        logic [63:0] k;
        logic [31:0] p;
        logic [63:0] e;
        if (a == b) return;
        k = tbl_key[a]; tbl_key[a] = tbl_key[b]; tbl_key[b] = k;
        p = tbl_pid[a]; tbl_pid[a] = tbl_pid[b]; tbl_pid[b] = p;
        e = tbl_ent[a]; tbl_ent[a] = tbl_ent[b]; tbl_ent[b] = e;
    endfunction

    function automatic t_answer apply_op(t_op_beat b);
        t_answer r;
        t_status st;
        int      pos;
        bit      show;
        r = '0;
        st = ST_OK;
        pos = Capacity;
        show = 1'b0;
        if (b.opcode > OP_READ || (b.opcode != OP_READ && b.session_key == 0)) begin
            st = ST_INVALID;
        end else begin
            case (t_opcode'(b.opcode))
                OP_REGISTER: begin
                    if (find_key(b.session_key) != Capacity) st = ST_DUPLICATE;
                    else if (n_stored >= Capacity) st = ST_FULL;
                    else begin
                        tbl_key[n_stored] = b.session_key;
                        tbl_pid[n_stored] = '0;
                        tbl_ent[n_stored] = '0;
                        n_stored++;
                    end
                end
                OP_BIND: begin
                    if (b.player_id == 0 || b.entity_key == 0) st = ST_INVALID;
                    else if ((pos = find_key(b.session_key)) == Capacity) st = ST_NOT_FOUND;
                    else if (pos < n_joined) st = ST_WRONG_STATE;
                    else if (entity_held(b.entity_key)) st = ST_ENTITY_USED;
                    else begin
                        swap_rows(pos, n_joined);
                        tbl_pid[n_joined] = b.player_id;
                        tbl_ent[n_joined] = b.entity_key;
                        n_joined++;
                    end
                end
                OP_REBIND: begin
                    if (b.entity_key == 0) st = ST_INVALID;
                    else if ((pos = find_key(b.session_key)) == Capacity) st = ST_NOT_FOUND;
                    else if (pos >= n_joined) st = ST_WRONG_STATE;
                    else if (entity_held(b.entity_key)) st = ST_ENTITY_USED;
                    else tbl_ent[pos] = b.entity_key;
                end
                OP_FIND: begin
                    if ((pos = find_key(b.session_key)) == Capacity) st = ST_NOT_FOUND;
                    else show = 1'b1;
                end
                OP_REMOVE: begin
                    if ((pos = find_key(b.session_key)) == Capacity) st = ST_NOT_FOUND;
                    else begin
                        if (pos < n_joined) begin
                            swap_rows(pos, n_joined - 1);
                            n_joined--;
                            pos = n_joined;
                        end
                        swap_rows(pos, n_stored - 1);
                        n_stored--;
                    end
                end
                default: begin
                    if (b.dense_index >= n_stored) st = ST_NOT_FOUND;
                    else begin
                        pos = b.dense_index;
                        show = 1'b1;
                    end
                end
            endcase
        end
        r.status = st;
        if (show) begin
            r.found_session_key = tbl_key[pos];
            r.found_player_id = tbl_pid[pos];
            r.found_entity_key = tbl_ent[pos];
            r.found_joined = (pos < n_joined);
            r.found_position = pos[5:0];
        end
        r.session_count = n_stored[6:0];
        r.joined_count = n_joined[6:0];
        return r;
    endfunction

    function automatic t_op_beat make_op(t_opcode o, logic [63:0] k, logic [31:0] p,
                                         logic [63:0] e, logic [5:0] d);
        t_op_beat b;
        b.opcode = o;
        b.session_key = k;
        b.player_id = p;
        b.entity_key = e;
        b.dense_index = d;
        return b;
    endfunction

    function automatic t_answer status_only(t_status st, int sc, int jc);
        t_answer r;
        r = '0;
        r.status = st;
        r.session_count = sc[6:0];
        r.joined_count = jc[6:0];
        return r;
    endfunction

    // Session keys drawn from a small pool so that hits, duplicates and misses all occur.
    logic [63:0] key_pool[24];
    logic [63:0] ent_pool[12];

    initial begin
        op_ch.valid = 1'b0;
        op_ch.opcode = '0;
        op_ch.session_key = '0;
        op_ch.player_id = '0;
        op_ch.entity_key = '0;
        op_ch.dense_index = '0;
        ans_ch.ready = 1'b0;
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom(), $urandom()} | 64'd1;
        for (int i = 0; i < 12; i++) ent_pool[i] = {$urandom(), $urandom()} | 64'd1;
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'd1;
        ent_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        ent_pool[1] = 64'd1;
    end

    task automatic send_beat(t_op_beat b);
        op_ch.valid <= 1'b1;
        op_ch.opcode <= b.opcode;
        op_ch.session_key <= b.session_key;
        op_ch.player_id <= b.player_id;
        op_ch.entity_key <= b.entity_key;
        op_ch.dense_index <= b.dense_index;
        do @(posedge i_clk); while (!op_ch.ready);
        sent_ops++;
    endtask

    task automatic idle_cycles(int n);
        op_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic issue(t_op_beat b, bit has_answer, t_answer hand);
        t_answer p;
        p = apply_op(b);
        if (has_answer && p != hand) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with prediction: %h vs %h", hand, p);
        end
        pending_answers.insert(pending_answers.size(), p);
        send_beat(b);
    endtask

    function automatic t_op_beat random_op();
        t_op_beat b;
        int      sel;
        b.session_key = key_pool[$urandom_range(0, 23)];
        b.player_id = $urandom_range(1, 100) == 1 ? 32'd0 : $urandom();
        b.entity_key = ent_pool[$urandom_range(0, 11)];
        b.dense_index = $urandom_range(0, 63);
        sel = $urandom_range(0, 99);
        if (sel < 25) b.opcode = OP_REGISTER;
        else if (sel < 45) b.opcode = OP_BIND;
        else if (sel < 55) b.opcode = OP_REBIND;
        else if (sel < 68) b.opcode = OP_FIND;
        else if (sel < 82) b.opcode = OP_REMOVE;
        else if (sel < 96) b.opcode = OP_READ;
        else b.opcode = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 39) == 0) b.session_key = 64'd0;
        else if ($urandom_range(0, 9) == 0) b.session_key = {$urandom(), $urandom()};
        if ($urandom_range(0, 39) == 0) b.entity_key = 64'd0;
        else if ($urandom_range(0, 9) == 0) b.entity_key = {$urandom(), $urandom()};
        return b;
    endfunction

    t_row rows[$];

    initial begin
        t_op_beat b;
        int       burst;
        mismatches = 0;
        sent_ops = 0;
        n_stored = 0;
        n_joined = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.insert(rows.size(), '{make_op(OP_FIND, key_pool[0], 0, 0, 0), 1,
                         status_only(ST_NOT_FOUND, 0, 0)});
        rows.insert(rows.size(), '{make_op(OP_READ, 0, 0, 0, 6'd0), 1,
                         status_only(ST_NOT_FOUND, 0, 0)});
        rows.insert(rows.size(), '{make_op(OP_REGISTER, 0, 0, 0, 0), 1,
                         status_only(ST_INVALID, 0, 0)});
        rows.insert(rows.size(), '{make_op(OP_REGISTER, key_pool[0], 0, 0, 0), 1,
                         status_only(ST_OK, 1, 0)});
        rows.insert(rows.size(), '{make_op(OP_REGISTER, key_pool[0], 0, 0, 0), 1,
                         status_only(ST_DUPLICATE, 1, 0)});
        rows.insert(rows.size(), '{make_op(OP_REGISTER, key_pool[1], 0, 0, 0), 1,
                         status_only(ST_OK, 2, 0)});
        rows.insert(rows.size(), '{make_op(OP_REGISTER, key_pool[2], 0, 0, 0), 1,
                         status_only(ST_OK, 3, 0)});
        rows.insert(rows.size(), '{make_op(OP_BIND, key_pool[2], 0, ent_pool[0], 0), 1,
                         status_only(ST_INVALID, 3, 0)});
        rows.insert(rows.size(), '{make_op(OP_BIND, key_pool[2], 1, 0, 0), 1,
                         status_only(ST_INVALID, 3, 0)});
        rows.insert(rows.size(), '{make_op(OP_BIND, key_pool[5], 1, ent_pool[0], 0), 1,
                         status_only(ST_NOT_FOUND, 3, 0)});
        rows.insert(rows.size(),
                    '{make_op(OP_BIND, key_pool[2], 32'hFFFF_FFFF, ent_pool[0], 0), 1,
                      status_only(ST_OK, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_BIND, key_pool[2], 5, ent_pool[1], 0), 1,
                         status_only(ST_WRONG_STATE, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_BIND, key_pool[1], 5, ent_pool[0], 0), 1,
                         status_only(ST_ENTITY_USED, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_REBIND, key_pool[1], 0, ent_pool[1], 0), 1,
                         status_only(ST_WRONG_STATE, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_REBIND, key_pool[2], 0, ent_pool[0], 0), 1,
                         status_only(ST_ENTITY_USED, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_REBIND, key_pool[2], 0, 0, 0), 1,
                         status_only(ST_INVALID, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_REBIND, key_pool[2], 0, ent_pool[1], 0), 0, '0});
        rows.insert(rows.size(), '{make_op(OP_FIND, key_pool[2], 0, 0, 0), 0, '0});
        rows.insert(rows.size(), '{make_op(OP_READ, 0, 0, 0, 6'd2), 0, '0});
        rows.insert(rows.size(), '{make_op(OP_READ, 0, 0, 0, 6'd63), 1,
                         status_only(ST_NOT_FOUND, 3, 1)});
        rows.insert(rows.size(), '{make_op(t_opcode'(3'd6), key_pool[1], 0, 0, 0), 1,
                         status_only(ST_INVALID, 3, 1)});
        rows.insert(rows.size(), '{make_op(t_opcode'(3'd7), key_pool[1], 0, 0, 0), 1,
                         status_only(ST_INVALID, 3, 1)});
        rows.insert(rows.size(), '{make_op(OP_REMOVE, key_pool[2], 0, 0, 0), 1,
                         status_only(ST_OK, 2, 0)});
        rows.insert(rows.size(), '{make_op(OP_REMOVE, key_pool[2], 0, 0, 0), 1,
                         status_only(ST_NOT_FOUND, 2, 0)});

        foreach (rows[i]) issue(rows[i].op, rows[i].has_answer, rows[i].answer);

        // Fill the table to capacity, then hit it once more for the full status.
        for (int i = 0; n_stored < Capacity; i++) begin
            issue(make_op(OP_REGISTER, {32'hA5A5_0000, 32'(i)} | 64'h1_0000_0000, 0, 0, 0),
                  0, '0);
        end
        issue(make_op(OP_REGISTER, 64'hDEAD_0000_0000_0001, 0, 0, 0), 1,
              status_only(ST_FULL, Capacity, 0));
        issue(make_op(OP_READ, 0, 0, 0, 6'd63), 0, '0);
        // Hold off until every answer has come back.
        idle_cycles(1);
        while (pending_answers.size() != 0) @(posedge i_clk);
        // Drain the full table with reads and removes of randomly chosen entries.
        while (n_stored > 0) begin
            issue(make_op(OP_READ, 0, 0, 0, 6'($urandom_range(0, n_stored - 1))), 0, '0);
            issue(make_op(OP_REMOVE, tbl_key[$urandom_range(0, n_stored - 1)], 0, 0, 0),
                  0, '0);
        end

        while (sent_ops < 1150) begin
            burst = $urandom_range(1, 30);
            repeat (burst) issue(random_op(), 0, '0);
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 150));
        end
        op_ch.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Receiver: alternates ready-always stretches with a random stall pattern.
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ans_ch.ready <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: ans_ch.ready <= 1'b1;
                1: ans_ch.ready <= ($urandom_range(0, 3) != 0);
                default: ans_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && ans_ch.valid && ans_ch.ready) begin
            got = {ans_ch.status, ans_ch.found_session_key, ans_ch.found_player_id,
                   ans_ch.found_entity_key, ans_ch.found_joined, ans_ch.found_position,
                   ans_ch.session_count, ans_ch.joined_count};
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = pending_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: status exp %0d got %0d", want.status, got.status);
                        $display("  key exp %h got %h", want.found_session_key,
                                 got.found_session_key);
                        $display("  pid exp %h got %h ent exp %h got %h",
                                 want.found_player_id, got.found_player_id,
                                 want.found_entity_key, got.found_entity_key);
                        $display("  joined/pos exp %0d/%0d got %0d/%0d",
                                 want.found_joined, want.found_position,
                                 got.found_joined, got.found_position);
                        $display("  counts exp %0d/%0d got %0d/%0d", want.session_count,
                                 want.joined_count, got.session_count, got.joined_count);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
design/pdst_pkg.sv
design/pdst_if.sv
design/pdst_ctrl.sv
design/pdst_dp.sv
design/partitioned_dense_session_table.sv
test/partitioned_dense_session_table_tb.sv
